@@ rtl/kdp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the 0/1 knapsack solver.
// No dependencies; imported by every module of the block.
package kdp_pkg;

    localparam int KDP_CAPACITY_MAX = 1023;
    localparam int WEIGHT_W         = 16;
    localparam int PROFIT_IN_W      = 16;
    localparam int PROFIT_W         = 22;
    localparam int CAP_W            = 10;
    localparam int CAP_RESET        = 1023;

    localparam logic [PROFIT_W-1:0] PROFIT_SAT = {PROFIT_W{1'b1}};

    typedef logic [PROFIT_W-1:0]    profit_t;
    typedef logic [PROFIT_IN_W-1:0] item_profit_t;
    typedef logic [WEIGHT_W-1:0]    item_weight_t;

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_WALK    = 3'd2;
    localparam logic [2:0] ST_DRAIN   = 3'd3;
    localparam logic [2:0] ST_RES_RD  = 3'd4;
    localparam logic [2:0] ST_RES_CAP = 3'd5;

endpackage

@@ rtl/kdp_row_mem.sv @@
`timescale 1ns / 1ps
// Best-profit row storage: one write port, two registered read ports.
// Depends on kdp_pkg for the entry type.
module kdp_row_mem
    import kdp_pkg::*;
#(
    parameter int DEPTH = KDP_CAPACITY_MAX + 1,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  profit_t       wr_data,
    input  logic [AW-1:0] rd_a_addr,
    input  logic [AW-1:0] rd_b_addr,
    output profit_t       rd_a_data,
    output profit_t       rd_b_data
);

    profit_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

@@ rtl/kdp_alu.sv @@
`timescale 1ns / 1ps
// Shared update unit: saturating add of profit to the shifted entry, then max.
// Depends on kdp_pkg for widths and the saturation limit.
module kdp_alu
    import kdp_pkg::*;
(
    input  logic         take,
    input  item_profit_t profit,
    input  profit_t      best_src,
    input  profit_t      best_old,
    output logic         upd_en,
    output profit_t      upd_data
);

    logic [PROFIT_W:0] sum;
    profit_t           cand;

    always_comb
    begin
        sum  = {1'b0, best_src} + (PROFIT_W + 1)'(profit);
        cand = sum[PROFIT_W] ? PROFIT_SAT : sum[PROFIT_W-1:0];
        // write back only when the candidate improves the entry
        upd_en   = take && (cand > best_old);
        upd_data = cand;
    end

endmodule

@@ rtl/zero_one_knapsack_dp.sv @@
`timescale 1ns / 1ps
// 0/1 knapsack solver. Each object transferred on the input stream updates a
// row of best profits over capacities CAPACITY_MAX down to 1, one entry per
// cycle through a single add/saturate/compare unit and a two-read-port row
// memory; s_tready stays low until the walk and its drain are done, so no new
// object is taken before the last one is through.
// An object with tlast set then reads best[capacity] (clamped to CAPACITY_MAX)
// into the output register, waiting while the previous result has not been
// taken, and then clears the row. The same clearing pass runs after reset; no
// object is accepted during it. The capacity register may be written at any
// time the block is idle.
// Depends on kdp_pkg, kdp_row_mem and kdp_alu.
module zero_one_knapsack_dp
    import kdp_pkg::*;
#(
    parameter int CAPACITY_MAX = KDP_CAPACITY_MAX
)
(
    input  logic             clk,
    input  logic             rst_n,
    // s_tdata: [15:0] item_weight, [31:16] item_profit; s_tlast: last_item
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,
    input  logic             s_tlast,
    // m_tdata: [21:0] max_profit, [23:22] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    // capacity register write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int DEPTH = CAPACITY_MAX + 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] JMAX = IW'(CAPACITY_MAX);
    localparam logic [IW-1:0] JONE = IW'(1);

    logic [2:0]       state_reg, state_next;
    logic [IW-1:0]    j_reg, j_next;
    item_weight_t     weight_reg, weight_next;
    item_profit_t     profit_reg, profit_next;
    logic             last_reg, last_next;
    logic [CAP_W-1:0] capacity_reg;

    logic             s1_valid_reg;
    logic             s1_take_reg;
    logic [IW-1:0]    s1_addr_reg;

    logic             out_valid_reg;
    profit_t          out_data_reg;

    logic [IW-1:0]    rd_a_addr, rd_b_addr;
    profit_t          rd_a_data, rd_b_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    profit_t          wr_data;
    logic             upd_en;
    profit_t          upd_data;
    logic             take;
    logic [IW-1:0]    cap_sel;
    logic             out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_data_reg};
    assign out_free  = !out_valid_reg || m_tready;

    assign take    = (weight_reg <= WEIGHT_W'(j_reg));
    assign cap_sel = (32'(capacity_reg) > CAPACITY_MAX) ? JMAX : IW'(capacity_reg);

    always_comb
    begin
        if (state_reg == ST_RES_RD || state_reg == ST_RES_CAP)
        begin
            rd_a_addr = cap_sel;
        end
        else
        begin
            rd_a_addr = j_reg;
        end
        rd_b_addr = j_reg - weight_reg[IW-1:0];
    end

    kdp_row_mem #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_row (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    kdp_alu u_alu (
        .take     (s1_valid_reg && s1_take_reg),
        .profit   (profit_reg),
        .best_src (rd_b_data),
        .best_old (rd_a_data),
        .upd_en   (upd_en),
        .upd_data (upd_data)
    );

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = j_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = upd_en;
            wr_addr = s1_addr_reg;
            wr_data = upd_data;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        weight_next = weight_reg;
        profit_next = profit_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (j_reg == JMAX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next = j_reg + JONE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    weight_next = s_tdata[15:0];
                    profit_next = s_tdata[31:16];
                    last_next   = s_tlast;
                    j_next      = JMAX;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // the walk never updates column zero
                if (j_reg == JONE)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg - JONE;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_RES_RD : ST_IDLE;
            end
            ST_RES_RD:
            begin
                state_next = ST_RES_CAP;
            end
            ST_RES_CAP:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    j_next     = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            j_reg         <= '0;
            last_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= CAP_W'(CAP_RESET);
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            last_reg     <= last_next;
            s1_valid_reg <= (state_reg == ST_WALK);
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (state_reg == ST_RES_CAP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg  <= weight_next;
        profit_reg  <= profit_next;
        s1_take_reg <= take;
        s1_addr_reg <= j_reg;
        if (state_reg == ST_RES_CAP && out_free)
        begin
            out_data_reg <= rd_a_data;
        end
    end

endmodule
